### design/quaternion_slerp_assert.svh
// Assertion macros for the slerp block; the enclosing module supplies clk and rst.
`ifndef QUATERNION_SLERP_ASSERT_SVH
`define QUATERNION_SLERP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/qslerp_pkg.sv
package qslerp_pkg;

  // Longest arctangent table the CORDIC units can use
  localparam int MAX_STAGES = 24;

  // Angle and CORDIC datapath word, Q.30 radians
  localparam int AW = 36;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t ANG_PI      = 36'sd3373259426;
  localparam ang_t ANG_HALF_PI = 36'sd1686629713;
  localparam ang_t ANG_TWO_PI  = 36'sd6746518852;
  localparam ang_t CORDIC_GAIN = 36'sd652032874;

  typedef struct packed {
    logic signed [15:0] p_w;
    logic signed [15:0] p_x;
    logic signed [15:0] p_y;
    logic signed [15:0] p_z;
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic [15:0]        fraction;
  } req_t;

  typedef struct packed {
    logic signed [15:0] r_w;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
  } rsp_t;

  // Values that ride along the pipeline beside the working registers
  typedef struct packed {
    logic signed [15:0] p_w;
    logic signed [15:0] p_x;
    logic signed [15:0] p_y;
    logic signed [15:0] p_z;
    logic [15:0]        fraction;
    logic signed [31:0] c;
    logic               spec;
    logic signed [25:0] vx;
    logic signed [25:0] vy;
    logic signed [25:0] vz;
    logic [24:0]        m;
    logic               neg;
    logic signed [31:0] cs;
    logic signed [31:0] sn;
  } side_t;

  // Arctangent of 2^-i in Q.30 radians
  function automatic ang_t atan_val(input int unsigned i);
    ang_t r;
    case (i)
      0:  r = 36'sd843314857;
      1:  r = 36'sd497837829;
      2:  r = 36'sd263043837;
      3:  r = 36'sd133525159;
      4:  r = 36'sd67021687;
      5:  r = 36'sd33543516;
      6:  r = 36'sd16775851;
      7:  r = 36'sd8388437;
      8:  r = 36'sd4194283;
      9:  r = 36'sd2097149;
      10: r = 36'sd1048576;
      11: r = 36'sd524288;
      12: r = 36'sd262144;
      13: r = 36'sd131072;
      14: r = 36'sd65536;
      15: r = 36'sd32768;
      16: r = 36'sd16384;
      17: r = 36'sd8192;
      18: r = 36'sd4096;
      19: r = 36'sd2048;
      20: r = 36'sd1024;
      21: r = 36'sd512;
      22: r = 36'sd256;
      23: r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/quaternion_slerp.sv
// Quaternion slerp: r = p * (conj(p) * q)^u, all parts signed Q1.14, u = fraction / 32768.
// Request channel: req_valid / req_stall carry one req_t beat (p, q, fraction).
// Response channel: rsp_valid / rsp_stall carry one rsp_t beat (r), saturated to Q1.14.
// A beat moves on a rising edge with valid high and stall low; one response per request,
// in request order.
// Throughput: one request per cycle, sustained while req_stall is low, with no dependence between requests.
// Pipeline: a request beat passes through the two bit-serial square roots (31 stages),
// the vectoring and rotation CORDIC chains (CORDIC_STAGES stages each, capped at
// MAX_STAGES) and the restoring divider (32 stages), plus the multiply and adder stages
// around them, before its response becomes valid.
// Back-pressure: the response register is backed by a one-beat skid register. When the
// receiver stalls, the pipeline hands its last beat to the skid and then freezes, and
// req_stall rises the cycle after; no beat is lost or repeated.
// Reset: rst (synchronous, active high) empties the pipeline, the skid and the output.
`include "quaternion_slerp_assert.svh"

module quaternion_slerp
  import qslerp_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int NS   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int SQ_N = 31;
  localparam int DV_N = 32;

  // Round half up from Q.44 to Q.14 and saturate
  function automatic logic signed [15:0] round_sat(input logic signed [49:0] v);
    logic signed [49:0] r;
    logic signed [15:0] o;
    r = (v + 50'sd536870912) >>> 30;
    if (r > 50'sd32767) begin
      o = 16'sh7fff;
    end else if (r < -50'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  logic  en;
  logic  skid_valid;
  rsp_t  skid;

  // Whole pipeline advances unless the skid register is occupied
  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  // ---------------------------------------------------------------------------------
  // Stage 1: partial products of conj(p) * q
  side_t              sd_in;
  logic               v1;
  side_t              sd1;
  logic signed [31:0] pr [0:15];

  always_comb begin
    sd_in          = '0;
    sd_in.p_w      = req.p_w;
    sd_in.p_x      = req.p_x;
    sd_in.p_y      = req.p_y;
    sd_in.p_z      = req.p_z;
    sd_in.fraction = req.fraction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1    <= sd_in;
      pr[0]  <= req.p_w * req.q_w;
      pr[1]  <= req.p_x * req.q_x;
      pr[2]  <= req.p_y * req.q_y;
      pr[3]  <= req.p_z * req.q_z;
      pr[4]  <= req.p_w * req.q_x;
      pr[5]  <= req.p_x * req.q_w;
      pr[6]  <= req.p_y * req.q_z;
      pr[7]  <= req.p_z * req.q_y;
      pr[8]  <= req.p_w * req.q_y;
      pr[9]  <= req.p_y * req.q_w;
      pr[10] <= req.p_z * req.q_x;
      pr[11] <= req.p_x * req.q_z;
      pr[12] <= req.p_w * req.q_z;
      pr[13] <= req.p_z * req.q_w;
      pr[14] <= req.p_x * req.q_y;
      pr[15] <= req.p_y * req.q_x;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 2: sum into d, exact in Q.28
  logic               v2;
  side_t              sd2;
  logic signed [33:0] dw, dx, dy, dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2 <= sd1;
      dw  <= 34'(pr[0]) + 34'(pr[1]) + 34'(pr[2]) + 34'(pr[3]);
      dx  <= 34'(pr[4]) - 34'(pr[5]) - 34'(pr[6]) + 34'(pr[7]);
      dy  <= 34'(pr[8]) - 34'(pr[9]) - 34'(pr[10]) + 34'(pr[11]);
      dz  <= 34'(pr[12]) - 34'(pr[13]) - 34'(pr[14]) + 34'(pr[15]);
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 3: clamp d_w to +-1.0, square it, reduce the vector part and square it
  logic signed [33:0] dw_cl;
  logic signed [31:0] c3;
  logic [30:0]        cmag;
  logic [61:0]        cmag_w;
  logic signed [25:0] vx3, vy3, vz3;
  logic signed [51:0] vxw, vyw, vzw;
  side_t              sd3_in;
  logic               v3;
  side_t              sd3;
  logic [61:0]        csq;
  logic signed [51:0] vxs, vys, vzs;

  always_comb begin
    if (dw > 34'sd268435456) begin
      dw_cl = 34'sd268435456;
    end else if (dw < -34'sd268435456) begin
      dw_cl = -34'sd268435456;
    end else begin
      dw_cl = dw;
    end
    c3     = {dw_cl[29:0], 2'b00};
    cmag   = (c3 < 0) ? 31'(-c3) : 31'(c3);
    cmag_w = {31'b0, cmag};
    vx3    = dx[33:8];
    vy3    = dy[33:8];
    vz3    = dz[33:8];
    vxw    = 52'(vx3);
    vyw    = 52'(vy3);
    vzw    = 52'(vz3);
    sd3_in      = sd2;
    sd3_in.c    = c3;
    sd3_in.spec = (dw >= 34'sd268435456);
    sd3_in.vx   = vx3;
    sd3_in.vy   = vy3;
    sd3_in.vz   = vz3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3 <= sd3_in;
      csq <= cmag_w * cmag_w;
      vxs <= vxw * vxw;
      vys <= vyw * vyw;
      vzs <= vzw * vzw;
    end
  end

  // ---------------------------------------------------------------------------------
  // Square roots: lane 0 gives s = sqrt(1 - c^2), lane 1 gives m = |d_v|
  logic        sq_v   [0:SQ_N];
  side_t       sq_sd  [0:SQ_N];
  logic [61:0] sq_op  [0:SQ_N][0:1];
  logic [34:0] sq_rem [0:SQ_N][0:1];
  logic [30:0] sq_rt  [0:SQ_N][0:1];
  logic [51:0] vsum;

  assign vsum = vxs + vys + vzs;

  // Load operands
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sd[0]     <= sd3;
      sq_op[0][0]  <= (62'd1 << 60) - csq;
      sq_op[0][1]  <= {10'b0, vsum};
      sq_rem[0][0] <= '0;
      sq_rem[0][1] <= '0;
      sq_rt[0][0]  <= '0;
      sq_rt[0][1]  <= '0;
    end
  end

  // One root bit per stage, two operand bits consumed
  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [34:0] rem_sh [0:1];
    logic [34:0] trial  [0:1];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_sh[l] = {sq_rem[k][l][32:0], sq_op[k][l][61:60]};
        trial[l]  = {2'b00, sq_rt[k][l], 2'b01};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sd[k+1] <= sq_sd[k];
        for (int l = 0; l < 2; l++) begin
          sq_op[k+1][l] <= {sq_op[k][l][59:0], 2'b00};
          if (rem_sh[l] >= trial[l]) begin
            sq_rem[k+1][l] <= rem_sh[l] - trial[l];
            sq_rt[k+1][l]  <= {sq_rt[k][l][29:0], 1'b1};
          end else begin
            sq_rem[k+1][l] <= rem_sh[l];
            sq_rt[k+1][l]  <= {sq_rt[k][l][29:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Vectoring CORDIC: h = atan2(s, c)
  logic  vc_v  [0:NS];
  side_t vc_sd [0:NS];
  ang_t  vc_x  [0:NS];
  ang_t  vc_y  [0:NS];
  ang_t  vc_z  [0:NS];
  side_t vc_sd_in;
  ang_t  s_ext, c_ext;

  always_comb begin
    s_ext      = {5'b0, sq_rt[SQ_N][0]};
    c_ext      = ang_t'(sq_sd[SQ_N].c);
    vc_sd_in   = sq_sd[SQ_N];
    vc_sd_in.m = sq_rt[SQ_N][1][24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_v[0] <= 1'b0;
    end else if (en) begin
      vc_v[0] <= sq_v[SQ_N];
    end
  end

  // Turn a vector in the left half plane by a quarter turn first
  always_ff @(posedge clk) begin
    if (en) begin
      vc_sd[0] <= vc_sd_in;
      if (c_ext < 0) begin
        vc_x[0] <= s_ext;
        vc_y[0] <= -c_ext;
        vc_z[0] <= ANG_HALF_PI;
      end else begin
        vc_x[0] <= c_ext;
        vc_y[0] <= s_ext;
        vc_z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vc
    ang_t sx, sy;

    assign sx = vc_y[i] >>> i;
    assign sy = vc_x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vc_v[i+1] <= 1'b0;
      end else if (en) begin
        vc_v[i+1] <= vc_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vc_sd[i+1] <= vc_sd[i];
        if (vc_y[i] > 0) begin
          vc_x[i+1] <= vc_x[i] + sx;
          vc_y[i+1] <= vc_y[i] - sy;
          vc_z[i+1] <= vc_z[i] + atan_val(i);
        end else begin
          vc_x[i+1] <= vc_x[i] - sx;
          vc_y[i+1] <= vc_y[i] + sy;
          vc_z[i+1] <= vc_z[i] - atan_val(i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Scale the half angle by u
  logic signed [52:0] hw, uw, hu;
  logic               vm;
  side_t              sdm;
  ang_t               nh;

  assign hw = 53'(vc_z[NS]);
  assign uw = {37'b0, vc_sd[NS].fraction};
  assign hu = hw * uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vc_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdm <= vc_sd[NS];
      nh  <= hu[50:15];
    end
  end

  // ---------------------------------------------------------------------------------
  // Wrap into [-pi, pi], then fold into [-pi/2, pi/2] with a sign flip
  ang_t  a_wr, a_fd;
  logic  neg_fd;
  side_t sdw_in;

  always_comb begin
    if (nh > ANG_PI) begin
      a_wr = nh - ANG_TWO_PI;
    end else if (nh < -ANG_PI) begin
      a_wr = nh + ANG_TWO_PI;
    end else begin
      a_wr = nh;
    end
    if (a_wr > ANG_HALF_PI) begin
      a_fd   = a_wr - ANG_PI;
      neg_fd = 1'b1;
    end else if (a_wr < -ANG_HALF_PI) begin
      a_fd   = a_wr + ANG_PI;
      neg_fd = 1'b1;
    end else begin
      a_fd   = a_wr;
      neg_fd = 1'b0;
    end
    sdw_in     = sdm;
    sdw_in.neg = neg_fd;
  end

  // ---------------------------------------------------------------------------------
  // Rotation CORDIC: cos and sin of the scaled angle
  logic  rc_v  [0:NS];
  side_t rc_sd [0:NS];
  ang_t  rc_x  [0:NS];
  ang_t  rc_y  [0:NS];
  ang_t  rc_z  [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_v[0] <= 1'b0;
    end else if (en) begin
      rc_v[0] <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc_sd[0] <= sdw_in;
      rc_x[0]  <= CORDIC_GAIN;
      rc_y[0]  <= '0;
      rc_z[0]  <= a_fd;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rc
    ang_t sx, sy;

    assign sx = rc_y[i] >>> i;
    assign sy = rc_x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        rc_v[i+1] <= 1'b0;
      end else if (en) begin
        rc_v[i+1] <= rc_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rc_sd[i+1] <= rc_sd[i];
        if (rc_z[i] >= 0) begin
          rc_x[i+1] <= rc_x[i] - sx;
          rc_y[i+1] <= rc_y[i] + sy;
          rc_z[i+1] <= rc_z[i] - atan_val(i);
        end else begin
          rc_x[i+1] <= rc_x[i] + sx;
          rc_y[i+1] <= rc_y[i] - sy;
          rc_z[i+1] <= rc_z[i] + atan_val(i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Undo the fold sign
  ang_t  cs_f, sn_f;
  side_t sd_t1_in;
  logic  v_t1;
  side_t sd_t1;

  always_comb begin
    cs_f        = rc_sd[NS].neg ? -rc_x[NS] : rc_x[NS];
    sn_f        = rc_sd[NS].neg ? -rc_y[NS] : rc_y[NS];
    sd_t1_in    = rc_sd[NS];
    sd_t1_in.cs = cs_f[31:0];
    sd_t1_in.sn = sn_f[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t1 <= 1'b0;
    end else if (en) begin
      v_t1 <= rc_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_t1 <= sd_t1_in;
    end
  end

  // ---------------------------------------------------------------------------------
  // Numerators v_i * sin
  logic signed [57:0] snw;
  logic signed [57:0] vw [0:2];
  logic               v_t2;
  side_t              sd_t2;
  logic signed [57:0] num [0:2];

  assign snw   = 58'(sd_t1.sn);
  assign vw[0] = 58'(sd_t1.vx);
  assign vw[1] = 58'(sd_t1.vy);
  assign vw[2] = 58'(sd_t1.vz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t2 <= 1'b0;
    end else if (en) begin
      v_t2 <= v_t1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_t2 <= sd_t1;
      for (int l = 0; l < 3; l++) begin
        num[l] <= vw[l] * snw;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Restoring divider by m, one quotient bit per stage, three lanes
  logic        dv_v   [0:DV_N];
  side_t       dv_sd  [0:DV_N];
  logic [56:0] dv_rem [0:DV_N][0:2];
  logic [31:0] dv_q   [0:DV_N][0:2];
  logic        dv_sg  [0:DV_N][0:2];
  logic signed [57:0] num_abs [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_abs[l] = (num[l] < 0) ? -num[l] : num[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v_t2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sd[0] <= sd_t2;
      for (int l = 0; l < 3; l++) begin
        dv_rem[0][l] <= num_abs[l][56:0];
        dv_q[0][l]   <= '0;
        dv_sg[0][l]  <= (num[l] < 0);
      end
    end
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    logic [56:0] dvs;

    assign dvs = 57'(dv_sd[j].m) << (DV_N - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sd[j+1] <= dv_sd[j];
        for (int l = 0; l < 3; l++) begin
          dv_sg[j+1][l] <= dv_sg[j][l];
          if (dv_rem[j][l] >= dvs) begin
            dv_rem[j+1][l] <= dv_rem[j][l] - dvs;
            dv_q[j+1][l]   <= {dv_q[j][l][30:0], 1'b1};
          end else begin
            dv_rem[j+1][l] <= dv_rem[j][l];
            dv_q[j+1][l]   <= {dv_q[j][l][30:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Build t; fall back to the x axis when the angle or the vector part is zero
  logic               use_x;
  logic signed [31:0] qs [0:2];
  logic               t_v;
  side_t              t_sd;
  logic signed [31:0] t_w, t_x, t_y, t_z;

  always_comb begin
    use_x = dv_sd[DV_N].spec || (dv_sd[DV_N].m == '0);
    for (int l = 0; l < 3; l++) begin
      qs[l] = dv_sg[DV_N][l] ? -$signed(dv_q[DV_N][l]) : $signed(dv_q[DV_N][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (en) begin
      t_v <= dv_v[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_sd <= dv_sd[DV_N];
      t_w  <= dv_sd[DV_N].cs;
      if (use_x) begin
        t_x <= dv_sd[DV_N].sn;
        t_y <= '0;
        t_z <= '0;
      end else begin
        t_x <= qs[0];
        t_y <= qs[1];
        t_z <= qs[2];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Partial products of p * t
  logic               f1_v;
  logic signed [47:0] fp [0:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fp[0]  <= t_sd.p_w * t_w;
      fp[1]  <= t_sd.p_x * t_x;
      fp[2]  <= t_sd.p_y * t_y;
      fp[3]  <= t_sd.p_z * t_z;
      fp[4]  <= t_sd.p_w * t_x;
      fp[5]  <= t_sd.p_x * t_w;
      fp[6]  <= t_sd.p_y * t_z;
      fp[7]  <= t_sd.p_z * t_y;
      fp[8]  <= t_sd.p_w * t_y;
      fp[9]  <= t_sd.p_y * t_w;
      fp[10] <= t_sd.p_z * t_x;
      fp[11] <= t_sd.p_x * t_z;
      fp[12] <= t_sd.p_w * t_z;
      fp[13] <= t_sd.p_z * t_w;
      fp[14] <= t_sd.p_x * t_y;
      fp[15] <= t_sd.p_y * t_x;
    end
  end

  // ---------------------------------------------------------------------------------
  // Sum, round and saturate
  logic signed [49:0] sum_w, sum_x, sum_y, sum_z;
  logic               fin_v;
  rsp_t               fin;

  assign sum_w = 50'(fp[0]) - (50'(fp[1]) + 50'(fp[2]) + 50'(fp[3]));
  assign sum_x = 50'(fp[4]) + 50'(fp[5]) + (50'(fp[6]) - 50'(fp[7]));
  assign sum_y = 50'(fp[8]) + 50'(fp[9]) + (50'(fp[10]) - 50'(fp[11]));
  assign sum_z = 50'(fp[12]) + 50'(fp[13]) + (50'(fp[14]) - 50'(fp[15]));

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (en) begin
      fin_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin.r_w <= round_sat(sum_w);
      fin.r_x <= round_sat(sum_x);
      fin.r_y <= round_sat(sum_y);
      fin.r_z <= round_sat(sum_z);
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register with skid: drain the skid first, park a beat there on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= fin_v;
      end
    end else if (fin_v) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      rsp <= skid_valid ? skid : fin;
    end else if (en) begin
      skid <= fin;
    end
  end

  // ---------------------------------------------------------------------------------
  `QS_ASSERT_SAME(a_skid_behind_output, skid_valid, rsp_valid,
                  "skid register holds a beat while the output register is empty")
  `QS_ASSERT_NEXT(a_stall_parks_beat, rsp_valid && rsp_stall && fin_v && en, skid_valid,
                  "beat leaving the pipeline under a stall was not parked")
  `QS_ASSERT_NEXT(a_freeze_holds_tail, !en, $stable(fin_v) && $stable(fin),
                  "pipeline tail moved while frozen")
  `QS_ASSERT_SAME(a_axis_fallback, t_v && (t_sd.spec || t_sd.m == '0),
                  t_y == '0 && t_z == '0, "x axis fallback left y or z non-zero")

endmodule
